// ----- sv/fsgg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsgg_pkg: shared types and constants for the feed sequence gap guard
// Table sizes, stream layouts, result codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fsgg_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int LENGTH_BITS = 16;

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int SEQ_W     = 64;
    localparam int DIGEST_W  = 64;
    localparam int LIMIT_W   = 11;
    localparam int STORED_W  = 11;
    localparam int BYTE_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_KNOWN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEQ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = 2'd3;

    localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST = 11'd1024;
    localparam logic [BYTE_W-1:0]  BYTE_LIMIT_RST  = 64'd67108864;

    typedef enum logic [2:0] {
        OC_FIRST    = 3'd0,
        OC_CONTIG   = 3'd1,
        OC_GAP      = 3'd2,
        OC_DUP      = 3'd3,
        OC_CONFLICT = 3'd4,
        OC_BACKWARD = 3'd5,
        OC_POISONED = 3'd6,
        OC_CAPACITY = 3'd7
    } outcome_t;

    typedef enum logic [1:0] {
        GS_UNSEEN   = 2'd0,
        GS_TRACKING = 2'd1,
        GS_DEGRADED = 2'd2,
        GS_POISONED = 2'd3
    } guard_t;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic [DIGEST_W-1:0]    digest_word3;
        logic [DIGEST_W-1:0]    digest_word2;
        logic [DIGEST_W-1:0]    digest_word1;
        logic [DIGEST_W-1:0]    digest_word0;
        logic [LENGTH_BITS-1:0] payload_length;
        logic [SEQ_W-1:0]       sequence_req;
    } in_item_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [STORED_W-1:0] stored_entries;
        logic                start_unknown_flag;
        logic [SEQ_W-1:0]    gap_end;
        logic [SEQ_W-1:0]    gap_begin;
        logic                gap_present;
        guard_t              guard_state;
        outcome_t            outcome;
    } out_item_t;

    // One stored table entry
    typedef struct packed {
        logic [4*DIGEST_W-1:0]  digest;
        logic [LENGTH_BITS-1:0] length;
        logic [SEQ_W-1:0]       seq;
    } entry_t;

    localparam int IN_BITS     = $bits(in_item_t);
    localparam int OUT_BITS    = $bits(out_item_t);
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic load;     // capture the accepted item
        logic eval;     // register the compare flags, open the search window
        logic rd_mid;   // read the table at the window midpoint
        logic step;     // narrow the window from the probe result
        logic rd_lo;    // read the table at the window floor
        logic check;    // classify the old sequence from the final read
        logic commit;   // update guard state and load the result register
    } cmd_t;

    typedef struct packed {
        logic lookup;   // item needs the table search
        logic more;     // search window is not empty
        logic out_free; // result register can take a new result
    } status_t;

endpackage : fsgg_pkg
`default_nettype wire

// ----- sv/fsgg_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsgg_ctrl: sequencing controller for the feed sequence gap guard
// Steps one transaction through evaluation, the binary search over the
// entry table when the item needs it, and the final commit.
// ----------------------------------------------------------------------------
module fsgg_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  fsgg_pkg::status_t status,
    output fsgg_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ROUTE,
        S_SEARCH,
        S_STEP,
        S_CHECK,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_ROUTE;
            end
            S_ROUTE: begin
                state_next = status.lookup ? S_SEARCH : S_COMMIT;
            end
            S_SEARCH: begin
                if (status.more) begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_STEP;
                end else begin
                    cmd.rd_lo  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_STEP: begin
                cmd.step   = 1'b1;
                state_next = S_SEARCH;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the result register drains
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule : fsgg_ctrl
`default_nettype wire

// ----- sv/fsgg_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsgg_dp: datapath for the feed sequence gap guard
// Configuration registers, guard state, entry table memory, search window
// and the result register.
// ----------------------------------------------------------------------------
module fsgg_dp (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      cfg_wr_en,
    input  wire  [fsgg_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire  [fsgg_pkg::CFG_DATA_W-1:0]          cfg_wr_data,
    input  wire  [fsgg_pkg::IN_TDATA_W-1:0]          s_tdata,
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    output logic [fsgg_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  fsgg_pkg::cmd_t                           cmd,
    output fsgg_pkg::status_t                        status
);

    // configuration
    logic                                first_known_reg;
    logic [fsgg_pkg::SEQ_W-1:0]          first_seq_reg;
    logic [fsgg_pkg::LIMIT_W-1:0]        entry_limit_reg;
    logic [fsgg_pkg::BYTE_W-1:0]         byte_limit_reg;

    // guard state
    fsgg_pkg::guard_t                    run_state_reg, run_state_next;
    logic [fsgg_pkg::SEQ_W-1:0]          top_seq_reg, top_seq_next;
    logic                                top_valid_reg, top_valid_next;
    logic                                su_reg, su_next;
    logic [fsgg_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [fsgg_pkg::BYTE_W-1:0]         byte_total_reg, byte_total_next;

    // item and evaluation flags
    fsgg_pkg::in_item_t                  item_reg;
    logic                                poisoned_reg;
    logic                                old_reg;
    logic                                contig_reg;
    logic                                first_eq_reg;
    logic                                first_gt_reg;
    logic                                cap_reg;
    logic [fsgg_pkg::SEQ_W-1:0]          next_top_reg;
    fsgg_pkg::outcome_t                  lookup_oc_reg;

    // search window
    logic [fsgg_pkg::COUNT_W-1:0]        lo_reg;
    logic [fsgg_pkg::COUNT_W-1:0]        hi_reg;
    logic [fsgg_pkg::COUNT_W-1:0]        mid_reg;
    logic [fsgg_pkg::COUNT_W-1:0]        mid;

    // entry table
    fsgg_pkg::entry_t                    mem [fsgg_pkg::TABLE_DEPTH];
    fsgg_pkg::entry_t                    rd_data_reg;
    logic                                mem_we;
    logic [fsgg_pkg::ADDR_W-1:0]         rd_addr;
    fsgg_pkg::entry_t                    wr_entry;

    // result
    logic                                out_valid_reg;
    fsgg_pkg::out_item_t                 out_reg, out_next;

    logic [fsgg_pkg::BYTE_W-1:0]         len_ext;
    logic [4*fsgg_pkg::DIGEST_W-1:0]     item_digest;

    assign len_ext     = fsgg_pkg::BYTE_W'(item_reg.payload_length);
    assign item_digest = {item_reg.digest_word3, item_reg.digest_word2,
                          item_reg.digest_word1, item_reg.digest_word0};
    assign mid         = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign status.lookup   = !poisoned_reg && old_reg;
    assign status.more     = lo_reg < hi_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = fsgg_pkg::OUT_TDATA_W'(out_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_known_reg <= 1'b0;
            first_seq_reg   <= '0;
            entry_limit_reg <= fsgg_pkg::ENTRY_LIMIT_RST;
            byte_limit_reg  <= fsgg_pkg::BYTE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fsgg_pkg::REG_FIRST_KNOWN: first_known_reg <= cfg_wr_data[0];
                fsgg_pkg::REG_FIRST_SEQ:   first_seq_reg   <= cfg_wr_data;
                fsgg_pkg::REG_ENTRY_LIMIT:
                    entry_limit_reg <= cfg_wr_data[fsgg_pkg::LIMIT_W-1:0];
                fsgg_pkg::REG_BYTE_LIMIT:  byte_limit_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // item capture, evaluation flags and search window
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= fsgg_pkg::in_item_t'(s_tdata[fsgg_pkg::IN_BITS-1:0]);
        end
        if (cmd.eval) begin
            poisoned_reg <= run_state_reg == fsgg_pkg::GS_POISONED;
            old_reg      <= top_valid_reg && (item_reg.sequence_req <= top_seq_reg);
            contig_reg   <= (item_reg.sequence_req - top_seq_reg) ==
                            fsgg_pkg::SEQ_W'(1);
            first_eq_reg <= item_reg.sequence_req == first_seq_reg;
            first_gt_reg <= item_reg.sequence_req > first_seq_reg;
            cap_reg      <= (64'(count_reg) >= 64'(entry_limit_reg))
                         || (64'(count_reg) >= 64'(fsgg_pkg::TABLE_DEPTH))
                         || (len_ext > byte_limit_reg)
                         || (byte_total_reg > (byte_limit_reg - len_ext));
            next_top_reg <= top_valid_reg ? top_seq_reg + fsgg_pkg::SEQ_W'(1)
                                          : first_seq_reg;
            lo_reg       <= '0;
            hi_reg       <= count_reg;
        end
        if (cmd.rd_mid) begin
            mid_reg <= mid;
        end
        if (cmd.step) begin
            if (rd_data_reg.seq < item_reg.sequence_req) begin
                lo_reg <= mid_reg + fsgg_pkg::COUNT_W'(1);
            end else begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.check) begin
            if (!(lo_reg < count_reg) || rd_data_reg.seq != item_reg.sequence_req) begin
                lookup_oc_reg <= fsgg_pkg::OC_BACKWARD;
            end else if (rd_data_reg.length == item_reg.payload_length &&
                         rd_data_reg.digest == item_digest) begin
                lookup_oc_reg <= fsgg_pkg::OC_DUP;
            end else begin
                lookup_oc_reg <= fsgg_pkg::OC_CONFLICT;
            end
        end
    end

    // entry table: one write port, one registered read port
    assign rd_addr = cmd.rd_mid ? mid[fsgg_pkg::ADDR_W-1:0]
                                : lo_reg[fsgg_pkg::ADDR_W-1:0];
    assign wr_entry = '{digest: item_digest,
                        length: item_reg.payload_length,
                        seq:    item_reg.sequence_req};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[fsgg_pkg::ADDR_W-1:0]] <= wr_entry;
        end
        if (cmd.rd_mid || cmd.rd_lo) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // commit: classify and update guard state
    always_comb begin
        fsgg_pkg::outcome_t oc;
        logic               gap;
        logic [fsgg_pkg::SEQ_W-1:0] gb;
        logic [fsgg_pkg::SEQ_W-1:0] ge;
        logic               su_after;
        logic               rejected;

        oc              = fsgg_pkg::OC_POISONED;
        gap             = 1'b0;
        gb              = '0;
        ge              = '0;
        su_after        = su_reg;
        rejected        = 1'b0;
        mem_we          = 1'b0;
        run_state_next  = run_state_reg;
        top_seq_next    = top_seq_reg;
        top_valid_next  = top_valid_reg;
        su_next         = su_reg;
        count_next      = count_reg;
        byte_total_next = byte_total_reg;

        if (poisoned_reg) begin
            oc = fsgg_pkg::OC_POISONED;
        end else if (old_reg) begin
            oc = lookup_oc_reg;
            if (lookup_oc_reg != fsgg_pkg::OC_DUP) begin
                run_state_next = fsgg_pkg::GS_POISONED;
            end
        end else begin
            if (!top_valid_reg) begin
                if (!first_known_reg) begin
                    oc       = fsgg_pkg::OC_FIRST;
                    su_after = 1'b1;
                end else if (first_eq_reg) begin
                    oc       = fsgg_pkg::OC_FIRST;
                    su_after = 1'b0;
                end else if (first_gt_reg) begin
                    oc       = fsgg_pkg::OC_GAP;
                    gap      = 1'b1;
                    gb       = next_top_reg;
                    ge       = item_reg.sequence_req;
                    su_after = 1'b0;
                end else begin
                    oc             = fsgg_pkg::OC_BACKWARD;
                    run_state_next = fsgg_pkg::GS_POISONED;
                    rejected       = 1'b1;
                end
            end else if (contig_reg) begin
                oc = fsgg_pkg::OC_CONTIG;
            end else begin
                oc  = fsgg_pkg::OC_GAP;
                gap = 1'b1;
                gb  = next_top_reg;
                ge  = item_reg.sequence_req;
            end
            if (!rejected) begin
                if (cap_reg) begin
                    oc             = fsgg_pkg::OC_CAPACITY;
                    gap            = 1'b0;
                    gb             = '0;
                    ge             = '0;
                    su_next        = su_reg || su_after;
                    run_state_next = fsgg_pkg::GS_POISONED;
                end else begin
                    mem_we          = cmd.commit;
                    count_next      = count_reg + fsgg_pkg::COUNT_W'(1);
                    byte_total_next = byte_total_reg + len_ext;
                    top_seq_next    = item_reg.sequence_req;
                    top_valid_next  = 1'b1;
                    su_next         = su_after;
                    if (oc == fsgg_pkg::OC_GAP || run_state_reg == fsgg_pkg::GS_DEGRADED) begin
                        run_state_next = fsgg_pkg::GS_DEGRADED;
                    end else begin
                        run_state_next = fsgg_pkg::GS_TRACKING;
                    end
                end
            end
        end

        out_next.outcome            = oc;
        out_next.guard_state        = run_state_next;
        out_next.gap_present        = gap;
        out_next.gap_begin          = gb;
        out_next.gap_end            = ge;
        out_next.start_unknown_flag = su_next;
        out_next.stored_entries     = fsgg_pkg::STORED_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_state_reg  <= fsgg_pkg::GS_UNSEEN;
            top_seq_reg    <= '0;
            top_valid_reg  <= 1'b0;
            su_reg         <= 1'b0;
            count_reg      <= '0;
            byte_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.commit) begin
                run_state_reg  <= run_state_next;
                top_seq_reg    <= top_seq_next;
                top_valid_reg  <= top_valid_next;
                su_reg         <= su_next;
                count_reg      <= count_next;
                byte_total_reg <= byte_total_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

endmodule : fsgg_dp
`default_nettype wire

// ----- sv/feed_sequence_gap_guard_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// feed_sequence_gap_guard_core: sequence gap guard for one message feed
// Classifies each message as first, contiguous, gap, duplicate, conflict,
// backward, poisoned or capacity, and keeps a table of accepted entries.
// ----------------------------------------------------------------------------
// Each input transaction carries a sequence number, a payload length and a
// 256-bit payload digest; each one yields exactly one result transaction.
// The block takes one transaction at a time. A message above the highest
// accepted sequence (or any message before one is accepted), or one that
// arrives while the guard is poisoned, needs no table search. A message at
// or below the highest accepted sequence is looked up by binary search in
// the entry table, a memory with one write port and one registered read
// port: each probe reads the table, then compares the entry. A finished
// result waits in an output register, so the next transaction is accepted
// before the result is taken; only the commit of the following message
// waits for that register to drain. Configuration registers (index 0
// first_sequence_known, 1 first_sequence, 2 entry_limit, 3 byte_limit)
// must be written only while the block is idle; the block does not enforce
// this. The entry table is not cleared at reset; only entries below the
// stored count affect a result.
module feed_sequence_gap_guard_core (
    input  wire                                   aclk,
    input  wire                                   aresetn,

    // configuration write port
    input  wire                                   cfg_wr_en,
    input  wire  [fsgg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [fsgg_pkg::CFG_DATA_W-1:0]       cfg_wr_data,

    // message input
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // from bit 0: sequence_req, payload_length, digest_word0..digest_word3
    input  wire  [fsgg_pkg::IN_TDATA_W-1:0]       s_tdata,

    // result output
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // from bit 0: outcome, guard_state, gap_present, gap_begin, gap_end,
    // start_unknown_flag, stored_entries, zero padding
    output logic [fsgg_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    // controller drives commands, datapath reports status back
    fsgg_pkg::cmd_t    cmd;
    fsgg_pkg::status_t status;

    // Sequencer: accept, evaluate, search the table when needed, commit.
    fsgg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: config, guard state, entry memory, result register.
    fsgg_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule : feed_sequence_gap_guard_core
`default_nettype wire
